### rtl/aes_pkg.sv
package aes_pkg;

    typedef struct packed {
        logic [63:0] plain_high;
        logic [63:0] plain_low;
    } t_in_item;

    typedef struct packed {
        logic [63:0] cipher_high;
        logic [63:0] cipher_low;
    } t_out_item;

    localparam int unsigned REG_KEY_WORD0 = 0;
    localparam int unsigned REG_KEY_WORD1 = 1;
    localparam int unsigned REG_KEY_WORD2 = 2;
    localparam int unsigned REG_KEY_WORD3 = 3;

    localparam logic [7:0] SBOX [256] = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };

    function automatic logic [7:0] xtime(input logic [7:0] a);
        return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic logic [31:0] sub_word(input logic [31:0] t);
        return {SBOX[t[31:24]], SBOX[t[23:16]], SBOX[t[15:8]], SBOX[t[7:0]]};
    endfunction

    // SubBytes and ShiftRows together; byte 0 is bits 127:120.
    function automatic logic [127:0] sub_shift(input logic [127:0] s);
        logic [127:0] t;
        t = '0;
        for (int c = 0; c < 4; c++) begin
            for (int r = 0; r < 4; r++) begin
                t[127 - 8 * (4 * c + r) -: 8] = SBOX[s[127 - 8 * (4 * ((c + r) % 4) + r) -: 8]];
            end
        end
        return t;
    endfunction

    function automatic logic [127:0] mix_columns(input logic [127:0] s);
        logic [127:0] t;
        logic [7:0]   a0, a1, a2, a3, al;
        t = '0;
        for (int c = 0; c < 4; c++) begin
            a0 = s[127 - 32 * c -: 8];
            a1 = s[119 - 32 * c -: 8];
            a2 = s[111 - 32 * c -: 8];
            a3 = s[103 - 32 * c -: 8];
            al = a0 ^ a1 ^ a2 ^ a3;
            t[127 - 32 * c -: 8] = a0 ^ al ^ xtime(a0 ^ a1);
            t[119 - 32 * c -: 8] = a1 ^ al ^ xtime(a1 ^ a2);
            t[111 - 32 * c -: 8] = a2 ^ al ^ xtime(a2 ^ a3);
            t[103 - 32 * c -: 8] = a3 ^ al ^ xtime(a3 ^ a0);
        end
        return t;
    endfunction

endpackage

### rtl/aes_key_expand.sv
module aes_key_expand #(
    parameter int NK = 8,
    parameter int NR = 14
) (
    input  logic                  i_clk,
    input  logic [255:0]          i_key,
    output logic [(NR+1)*128-1:0] o_round_keys
);
    import aes_pkg::*;

    localparam int NW = 4 * (NR + 1);

    // Schedule words; the user must change the key only while idle (the block does not
    // enforce it), so the schedule is registered and settles before any item is started.
    logic [31:0] n_w [NW];
    logic [31:0] r_w [NW];
    logic [7:0]  n_rc [NW];

    always_comb begin
        for (int i = 0; i < NW; i++) begin
            n_w[i]  = '0;
            n_rc[i] = 8'h01;
        end
        for (int i = 0; i < NW; i++) begin
            if (i < NK) begin
                n_w[i] = i_key[255 - 32 * i -: 32];
            end else if (i % NK == 0) begin
                n_w[i] = r_w[i - NK] ^ sub_word({r_w[i - 1][23:0], r_w[i - 1][31:24]})
                         ^ {n_rc[i - NK], 24'h0};
                n_rc[i] = xtime(n_rc[i - NK]);
            end else if (NK > 6 && i % NK == 4) begin
                n_w[i] = r_w[i - NK] ^ sub_word(r_w[i - 1]);
                n_rc[i] = n_rc[i - 1];
            end else begin
                n_w[i] = r_w[i - NK] ^ r_w[i - 1];
                n_rc[i] = n_rc[i - 1];
            end
        end
    end

    // One schedule word settles per cycle from the previous register values.
    always_ff @(posedge i_clk) begin
        for (int i = 0; i < NW; i++) begin
            r_w[i] <= n_w[i];
        end
    end

    always_comb begin
        for (int i = 0; i < NW; i++) begin
            o_round_keys[(NR + 1) * 128 - 1 - 32 * i -: 32] = r_w[i];
        end
    end

endmodule

### rtl/aes_round.sv
module aes_round #(
    parameter bit LAST = 1'b0
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_valid,
    input  logic [127:0] i_state,
    input  logic [127:0] i_round_key,
    output logic         o_valid,
    output logic [127:0] o_state
);
    import aes_pkg::*;

    logic [127:0] n_state;
    logic         r_valid;
    logic [127:0] r_state;

    // One full round between registers.
    always_comb begin
        if (LAST) begin
            n_state = sub_shift(i_state) ^ i_round_key;
        end else begin
            n_state = mix_columns(sub_shift(i_state)) ^ i_round_key;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
        r_state <= n_state;
    end

    assign o_valid = r_valid;
    assign o_state = r_state;

endmodule

### rtl/aes_block_encrypt.sv
// Channel  | Ports                          | Handshake
// input    | i_start, i_in (t_in_item)      | taken when i_start && !o_busy
// result   | o_done, o_out (t_out_item)     | one cycle, no hold-off
// config   | i_cfg_we, i_cfg_idx, i_cfg_data| written when i_cfg_we
//
// An item can be taken every cycle; o_busy is always low.
// A result passes through one register stage for the initial key add and
// one per round. The round-key schedule is registered and is rebuilt after
// a key write. Reset clears the key registers and the stage valid bits.
module aes_block_encrypt #(
    parameter int KEY_BITS = 256
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    output logic              o_busy,
    input  aes_pkg::t_in_item i_in,
    output logic              o_done,
    output aes_pkg::t_out_item o_out,
    input  logic              i_cfg_we,
    input  logic [1:0]        i_cfg_idx,
    input  logic [63:0]       i_cfg_data
);
    import aes_pkg::*;

    localparam int NK = (KEY_BITS >= 256) ? 8 : ((KEY_BITS >= 192) ? 6 : 4);
    localparam int NR = NK + 6;

    logic [63:0] r_key [4];
    logic [255:0] key_flat;
    logic [(NR+1)*128-1:0] round_keys;

    // Key registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 4; i++) r_key[i] <= '0;
        end else if (i_cfg_we) begin
            r_key[i_cfg_idx] <= i_cfg_data;
        end
    end

    assign key_flat = {r_key[REG_KEY_WORD0], r_key[REG_KEY_WORD1],
                       r_key[REG_KEY_WORD2], r_key[REG_KEY_WORD3]};

    aes_key_expand #(.NK(NK), .NR(NR)) u_key (
        .i_clk       (i_clk),
        .i_key       (key_flat),
        .o_round_keys(round_keys)
    );

    logic         v [NR + 1];
    logic [127:0] s [NR + 1];
    logic         r_v0;
    logic [127:0] r_s0;

    // Initial key add stage.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
        end else begin
            r_v0 <= i_start;
        end
        r_s0 <= i_in ^ round_keys[(NR + 1) * 128 - 1 -: 128];
    end

    assign v[0] = r_v0;
    assign s[0] = r_s0;

    // One register stage per round.
    for (genvar g = 1; g <= NR; g++) begin : g_round
        aes_round #(.LAST(g == NR)) u_round (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_valid    (v[g - 1]),
            .i_state    (s[g - 1]),
            .i_round_key(round_keys[(NR + 1 - g) * 128 - 1 -: 128]),
            .o_valid    (v[g]),
            .o_state    (s[g])
        );
    end

    assign o_busy = 1'b0;
    assign o_done = v[NR];
    assign o_out  = s[NR];

endmodule

### dv/tb.sv
`timescale 1ns / 100ps

module tb;
    import aes_pkg::*;

    localparam int KEY_BITS  = 256;
    localparam int KEY_WORDS = (KEY_BITS >= 256) ? 8 : ((KEY_BITS >= 192) ? 6 : 4);
    localparam int ROUNDS    = KEY_WORDS + 6;
    localparam int LATENCY   = ROUNDS + 2;
    localparam int SETTLE    = 4 * (ROUNDS + 1) - KEY_WORDS + 8;
    localparam int STALL_MAX = 2000;

    // One row of the directed part: an optional key load, the block, and an
    // expected block where it is known by heart.
    typedef struct {
        bit          load_key;
        logic [63:0] key_val [4];
        t_in_item    plain;
        bit          known;
        t_out_item   cipher;
    } t_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_start = 1'b0;
    logic        o_busy;
    t_in_item    i_in = '0;
    logic        o_done;
    t_out_item   o_out;
    logic        i_cfg_we = 1'b0;
    logic [1:0]  i_cfg_idx = '0;
    logic [63:0] i_cfg_data = '0;

    logic [63:0] key_shadow [4];
    t_out_item   cipher_q [$];
    int          err_count = 0;
    int          idle_cycles = 0;
    int          idle_pct = 0;

    always #1 i_clk = ~i_clk;

    aes_block_encrypt #(.KEY_BITS(KEY_BITS)) dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(i_start), .o_busy(o_busy),
        .i_in(i_in), .o_done(o_done), .o_out(o_out), .i_cfg_we(i_cfg_we),
        .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data)
    );

    function automatic logic [7:0] gf_double(logic [7:0] a);
        return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic logic [31:0] sbox_word(logic [31:0] t);
        return {SBOX[t[31:24]], SBOX[t[23:16]], SBOX[t[15:8]], SBOX[t[7:0]]};
    endfunction

    // Full AES encryption of one block under the shadow key.
    function automatic t_out_item aes_encrypt(t_in_item pt);
        logic [31:0]  w [60];
        logic [31:0]  t;
        logic [7:0]   rc;
        logic [127:0] s, u;
        logic [7:0]   a0, a1, a2, a3, al;
        rc = 8'h01;
        for (int i = 0; i < KEY_WORDS; i++) begin
            w[i] = (i % 2) ? key_shadow[i / 2][31:0] : key_shadow[i / 2][63:32];
        end
        for (int i = KEY_WORDS; i < 4 * (ROUNDS + 1); i++) begin
            t = w[i - 1];
            if (i % KEY_WORDS == 0) begin
                t = sbox_word({t[23:0], t[31:24]}) ^ {rc, 24'h0};
                rc = gf_double(rc);
            end else if (KEY_WORDS > 6 && i % KEY_WORDS == 4) begin
                t = sbox_word(t);
            end
            w[i] = w[i - KEY_WORDS] ^ t;
        end
        s = {pt.plain_high, pt.plain_low} ^ {w[0], w[1], w[2], w[3]};
        for (int rnd = 1; rnd <= ROUNDS; rnd++) begin
            // Byte substitution with the row rotation folded in.
            for (int c = 0; c < 4; c++) begin
                for (int r = 0; r < 4; r++) begin
                    u[127 - 8 * (4 * c + r) -: 8] = SBOX[s[127 - 8 * (4 * ((c + r) % 4) + r) -: 8]];
                end
            end
            s = u;
            if (rnd < ROUNDS) begin
                for (int c = 0; c < 4; c++) begin
                    a0 = s[127 - 32 * c -: 8];
                    a1 = s[119 - 32 * c -: 8];
                    a2 = s[111 - 32 * c -: 8];
                    a3 = s[103 - 32 * c -: 8];
                    al = a0 ^ a1 ^ a2 ^ a3;
                    u[127 - 32 * c -: 8] = a0 ^ al ^ gf_double(a0 ^ a1);
                    u[119 - 32 * c -: 8] = a1 ^ al ^ gf_double(a1 ^ a2);
                    u[111 - 32 * c -: 8] = a2 ^ al ^ gf_double(a2 ^ a3);
                    u[103 - 32 * c -: 8] = a3 ^ al ^ gf_double(a3 ^ a0);
                end
                s = u;
            end
            s = s ^ {w[4 * rnd], w[4 * rnd + 1], w[4 * rnd + 2], w[4 * rnd + 3]};
        end
        return s;
    endfunction

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    // Loads the whole key once the pipeline has drained, then lets the
    // round-key schedule settle.
    task automatic load_key(logic [63:0] kv [4]);
        while (cipher_q.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 4) @(posedge i_clk);
        for (int i = 0; i < 4; i++) begin
            i_cfg_we   <= 1'b1;
            i_cfg_idx  <= (i == 0) ? REG_KEY_WORD0[1:0] : (i == 1) ? REG_KEY_WORD1[1:0] :
                          (i == 2) ? REG_KEY_WORD2[1:0] : REG_KEY_WORD3[1:0];
            i_cfg_data <= kv[i];
            @(posedge i_clk);
            key_shadow[i] = kv[i];
        end
        i_cfg_we <= 1'b0;
        repeat (SETTLE) @(posedge i_clk);
    endtask

    // Offers one item, idling cycle by cycle at the current rate, and records
    // its expected ciphertext once it is taken.
    task automatic send_block(t_in_item pt, bit known, t_out_item ct);
        while ($urandom_range(99) < idle_pct) begin
            i_start <= 1'b0;
            @(posedge i_clk);
        end
        i_start <= 1'b1;
        i_in    <= pt;
        @(posedge i_clk);
        while (o_busy) @(posedge i_clk);
        cipher_q.push_back(known ? ct : aes_encrypt(pt));
    endtask

    // Result checker.
    always @(posedge i_clk) begin
        t_out_item exp_ct;
        if (i_rst_n && o_done) begin
            if (cipher_q.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual %h", $time, o_out);
                err_count++;
            end else begin
                exp_ct = cipher_q.pop_front();
                if (o_out.cipher_high !== exp_ct.cipher_high) begin
                    $display("%0t: cipher_high expected %h actual %h", $time,
                             exp_ct.cipher_high, o_out.cipher_high);
                    err_count++;
                end
                if (o_out.cipher_low !== exp_ct.cipher_low) begin
                    $display("%0t: cipher_low expected %h actual %h", $time,
                             exp_ct.cipher_low, o_out.cipher_low);
                    err_count++;
                end
            end
        end
    end

    // Watchdog on cycles where nothing moves.
    always @(posedge i_clk) begin
        if ((i_start && !o_busy) || o_done || i_cfg_we) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= STALL_MAX) begin
                $display("TEST FAILED");
                $finish;
            end
        end
    end

    initial begin
        t_row        rows [$];
        t_row        row;
        logic [63:0] kv [4];
        t_in_item    pt;

        for (int i = 0; i < 4; i++) key_shadow[i] = '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (SETTLE) @(posedge i_clk);

        // Directed part: zero key after reset, the standard test key, then
        // extreme keys and blocks.
        row = '{default: '0, key_val: '{default: '0}};
        row.known = 1'b1;
        row.cipher = 128'hdc95c078a2408989ad48a21492842087;
        rows.push_back(row);
        row = '{default: '0, key_val: '{default: '0}};
        row.plain = '1;
        rows.push_back(row);
        row.plain = {64'h8000000000000000, 64'h0};
        rows.push_back(row);
        row.plain = {64'h0, 64'h0000000000000001};
        rows.push_back(row);
        row = '{default: '0, key_val: '{default: '0}};
        row.load_key = 1'b1;
        row.key_val = '{64'h0001020304050607, 64'h08090a0b0c0d0e0f,
                        64'h1011121314151617, 64'h18191a1b1c1d1e1f};
        row.plain = 128'h00112233445566778899aabbccddeeff;
        row.known = 1'b1;
        row.cipher = 128'h8ea2b7ca516745bfeafc49904b496089;
        rows.push_back(row);
        row.load_key = 1'b0;
        row.known = 1'b0;
        row.plain = '0;
        rows.push_back(row);
        row.plain = '1;
        rows.push_back(row);
        row.load_key = 1'b1;
        row.key_val = '{default: '1};
        row.plain = '0;
        rows.push_back(row);
        row.load_key = 1'b0;
        row.plain = '1;
        rows.push_back(row);
        row.plain = 128'h5555aaaa5555aaaa5555aaaa5555aaaa;
        rows.push_back(row);
        row.load_key = 1'b1;
        row.key_val = '{64'h8000000000000000, 64'h0, 64'h0, 64'h1};
        row.plain = 128'h0123456789abcdeffedcba9876543210;
        rows.push_back(row);

        foreach (rows[r]) begin
            if (rows[r].load_key) begin
                i_start <= 1'b0;
                load_key(rows[r].key_val);
            end
            send_block(rows[r].plain, rows[r].known, rows[r].cipher);
        end

        // Random part: several random keys, idle rate changing by phase.
        for (int ph = 0; ph < 8; ph++) begin
            idle_pct = (ph < 3) ? 10 : (ph < 6) ? 52 : 0;
            for (int i = 0; i < 4; i++) kv[i] = rand64();
            i_start <= 1'b0;
            load_key(kv);
            for (int n = 0; n < 200; n++) begin
                pt = {rand64(), rand64()};
                send_block(pt, 1'b0, '0);
            end
        end
        i_start <= 1'b0;

        while (cipher_q.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 4) @(posedge i_clk);
        if (err_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

### sim.f
rtl/aes_pkg.sv
rtl/aes_key_expand.sv
rtl/aes_round.sv
rtl/aes_block_encrypt.sv
dv/tb.sv
